/* hw/rtl/wcpm_pkg.sv */
// Shared constants and controller/datapath handshake types for the centroid merge block.
package wcpm_pkg;

   // Default field widths.
   localparam int TIME_BITS_DEF  = 24;
   localparam int COUNT_BITS_DEF = 32;

   // Fixed accumulator widths.
   localparam int WSUM_BITS = 64;
   localparam int CSUM_BITS = 40;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch;   // capture the input transfer
      logic mul;     // form the product and the merge decision
      logic upd;     // fold the entry into the cluster state
      logic flush;   // hand the open cluster to the divider and close it
      logic dinit;   // load the divider and test for saturation
      logic dstep;   // one quotient bit
      logic oload;   // load the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic close;     // the entry closes the open cluster
      logic last;      // the entry ends the stream
      logic fin;       // the divider holds the final flush
      logic out_free;  // the result register can take a new result
   } stat_type;

endpackage

/* hw/rtl/wcpm_req_if.sv */
// Input channel: one histogram entry per transfer.
interface wcpm_req_if #(
   parameter int TIME_BITS  = wcpm_pkg::TIME_BITS_DEF,
   parameter int COUNT_BITS = wcpm_pkg::COUNT_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [TIME_BITS-1:0]  entry_time;
   logic [COUNT_BITS-1:0] entry_count;
   logic                  is_last;

   modport source (output valid, entry_time, entry_count, is_last, input ready);
   modport sink   (input valid, entry_time, entry_count, is_last, output ready);
endinterface

/* hw/rtl/wcpm_rsp_if.sv */
// Result channel: one closed cluster per transfer.
interface wcpm_rsp_if #(
   parameter int TIME_BITS  = wcpm_pkg::TIME_BITS_DEF,
   parameter int COUNT_BITS = wcpm_pkg::COUNT_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [TIME_BITS-1:0]  mean_time;
   logic [COUNT_BITS-1:0] total_count;
   logic                  sum_overflow;
   logic                  final_result;

   modport source (output valid, mean_time, total_count, sum_overflow, final_result,
                   input ready);
   modport sink   (input valid, mean_time, total_count, sum_overflow, final_result,
                   output ready);
endinterface

/* hw/rtl/wcpm_ctrl.sv */
// Sequencing state machine for the centroid merge block.
module wcpm_ctrl #(
   parameter int TIME_BITS = wcpm_pkg::TIME_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  wcpm_pkg::stat_type stat,
   output wcpm_pkg::cmd_type  cmd
);

   localparam int CW = $clog2(TIME_BITS);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL   = 3'd1;
   localparam logic [2:0] S_UPD   = 3'd2;
   localparam logic [2:0] S_FLUSH = 3'd3;
   localparam logic [2:0] S_DINIT = 3'd4;
   localparam logic [2:0] S_DSTEP = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   // New entries are taken only between items.
   assign req_ready = (state_ff == S_IDLE);

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_UPD;
         end
         S_UPD: begin
            cmd.upd = 1'b1;
            if (stat.close) begin
               state_in = S_DINIT;
            end else if (stat.last) begin
               state_in = S_FLUSH;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_FLUSH: begin
            cmd.flush = 1'b1;
            state_in  = S_DINIT;
         end
         S_DINIT: begin
            cmd.dinit = 1'b1;
            cnt_in    = '0;
            state_in  = S_DSTEP;
         end
         S_DSTEP: begin
            cmd.dstep = 1'b1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == CW'(TIME_BITS - 1)) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (stat.out_free) begin
               cmd.oload = 1'b1;
               // A closing entry that also ends the stream still owes the flush.
               if (!stat.fin && stat.last) begin
                  state_in = S_FLUSH;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and step counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

/* hw/rtl/wcpm_dp.sv */
// Datapath: cluster accumulators, bit-serial divider and result register.
module wcpm_dp #(
   parameter int TIME_BITS  = wcpm_pkg::TIME_BITS_DEF,
   parameter int COUNT_BITS = wcpm_pkg::COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  wcpm_pkg::cmd_type     cmd,
   output wcpm_pkg::stat_type    stat,
   input  logic                  csr_we,
   input  logic [TIME_BITS-1:0]  csr_wdata,
   input  logic [TIME_BITS-1:0]  req_time,
   input  logic [COUNT_BITS-1:0] req_count,
   input  logic                  req_last,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [TIME_BITS-1:0]  rsp_mean,
   output logic [COUNT_BITS-1:0] rsp_total,
   output logic                  rsp_ovf,
   output logic                  rsp_final
);

   localparam int WB    = wcpm_pkg::WSUM_BITS;
   localparam int CB    = wcpm_pkg::CSUM_BITS;
   localparam int PB    = TIME_BITS + COUNT_BITS;
   localparam int REM_W = CB + 1;
   localparam int CMP_W = WB + TIME_BITS;

   // Configuration.
   logic [TIME_BITS-1:0]  res_ff;

   // Captured entry and product.
   logic [TIME_BITS-1:0]  in_time_ff;
   logic [COUNT_BITS-1:0] in_count_ff;
   logic                  in_last_ff;
   logic [WB-1:0]         prod_ff;
   logic                  close_ff;

   // Open cluster.
   logic                  open_ff;
   logic [TIME_BITS-1:0]  start_ff;
   logic [WB-1:0]         wsum_ff;
   logic [CB-1:0]         csum_ff;
   logic                  ovf_ff;

   // Cluster under division.
   logic [WB-1:0]         dsum_ff;
   logic [CB-1:0]         dcnt_ff;
   logic [TIME_BITS-1:0]  dstart_ff;
   logic                  dovf_ff;
   logic                  dfin_ff;
   logic [REM_W-1:0]      rem_ff;
   logic [TIME_BITS-1:0]  lo_ff;
   logic [TIME_BITS-1:0]  quo_ff;
   logic                  sat_ff;

   // Result register.
   logic                  rsp_valid_ff;
   logic [TIME_BITS-1:0]  rsp_mean_ff;
   logic [COUNT_BITS-1:0] rsp_total_ff;
   logic                  rsp_ovf_ff;
   logic                  rsp_final_ff;

   logic [TIME_BITS-1:0]  time_delta;
   logic [PB-1:0]         prod_full;
   logic [WB:0]           wsum_add;
   logic [CB:0]           csum_add;
   logic [CMP_W-1:0]      sat_lhs;
   logic [CMP_W-1:0]      sat_rhs;
   logic [REM_W-1:0]      rem_sh;
   logic [REM_W-1:0]      dcnt_ext;
   logic                  qbit;
   logic [TIME_BITS-1:0]  mean_sel;
   logic [COUNT_BITS-1:0] total_sel;

   // Distance from the cluster start and the entry's weighted time.
   assign time_delta = (in_time_ff >= start_ff) ? (in_time_ff - start_ff)
                                                : (start_ff - in_time_ff);
   assign prod_full = PB'(in_time_ff) * PB'(in_count_ff);

   // Accumulator sums with a carry bit for saturation.
   assign wsum_add = {1'b0, wsum_ff} + {1'b0, prod_ff};
   assign csum_add = {1'b0, csum_ff} + (CB + 1)'(in_count_ff);

   // The quotient saturates exactly when the sum reaches count times 2^TIME_BITS.
   assign sat_lhs = CMP_W'(dsum_ff);
   assign sat_rhs = CMP_W'(dcnt_ff) << TIME_BITS;

   // One restoring division step.
   assign rem_sh   = {rem_ff[REM_W-2:0], lo_ff[TIME_BITS-1]};
   assign dcnt_ext = {1'b0, dcnt_ff};
   assign qbit     = (rem_sh >= dcnt_ext);

   // Result fields of the cluster under division.
   always_comb begin
      if (dcnt_ff == '0) begin
         mean_sel = dstart_ff;
      end else if (sat_ff) begin
         mean_sel = '1;
      end else begin
         mean_sel = quo_ff;
      end
      if (dcnt_ff[CB-1:COUNT_BITS] != '0) begin
         total_sel = '1;
      end else begin
         total_sel = dcnt_ff[COUNT_BITS-1:0];
      end
   end

   assign stat.close    = close_ff;
   assign stat.last     = in_last_ff;
   assign stat.fin      = dfin_ff;
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_mean  = rsp_mean_ff;
   assign rsp_total = rsp_total_ff;
   assign rsp_ovf   = rsp_ovf_ff;
   assign rsp_final = rsp_final_ff;

   // Control registers: configuration, cluster valid flag, result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff       <= '0;
         open_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            res_ff <= csr_wdata;
         end
         if (cmd.upd) begin
            open_ff <= 1'b1;
         end else if (cmd.flush) begin
            open_ff <= 1'b0;
         end
         if (cmd.oload) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Entry capture, product and merge decision.
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         in_time_ff  <= req_time;
         in_count_ff <= req_count;
         in_last_ff  <= req_last;
      end
      if (cmd.mul) begin
         prod_ff  <= WB'(prod_full);
         close_ff <= open_ff && (time_delta > res_ff);
      end
   end

   // Cluster accumulators and the hand-off to the divider.
   always_ff @(posedge clock) begin
      if (cmd.upd) begin
         if (open_ff && !close_ff) begin
            if (wsum_add[WB]) begin
               wsum_ff <= '1;
               ovf_ff  <= 1'b1;
            end else begin
               wsum_ff <= wsum_add[WB-1:0];
            end
            if (csum_add[CB]) begin
               csum_ff <= '1;
            end else begin
               csum_ff <= csum_add[CB-1:0];
            end
         end else begin
            start_ff <= in_time_ff;
            wsum_ff  <= prod_ff;
            csum_ff  <= CB'(in_count_ff);
            ovf_ff   <= 1'b0;
         end
         if (close_ff) begin
            dsum_ff   <= wsum_ff;
            dcnt_ff   <= csum_ff;
            dstart_ff <= start_ff;
            dovf_ff   <= ovf_ff;
            dfin_ff   <= 1'b0;
         end
      end else if (cmd.flush) begin
         dsum_ff   <= wsum_ff;
         dcnt_ff   <= csum_ff;
         dstart_ff <= start_ff;
         dovf_ff   <= ovf_ff;
         dfin_ff   <= 1'b1;
      end
   end

   // Bit-serial divider: one quotient bit per cycle.
   always_ff @(posedge clock) begin
      if (cmd.dinit) begin
         sat_ff <= (sat_lhs >= sat_rhs);
         rem_ff <= REM_W'(dsum_ff >> TIME_BITS);
         lo_ff  <= dsum_ff[TIME_BITS-1:0];
         quo_ff <= '0;
      end else if (cmd.dstep) begin
         rem_ff <= qbit ? (rem_sh - dcnt_ext) : rem_sh;
         lo_ff  <= {lo_ff[TIME_BITS-2:0], 1'b0};
         quo_ff <= {quo_ff[TIME_BITS-2:0], qbit};
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (cmd.oload) begin
         rsp_mean_ff  <= mean_sel;
         rsp_total_ff <= total_sel;
         rsp_ovf_ff   <= dovf_ff;
         rsp_final_ff <= dfin_ff;
      end
   end

endmodule

/* hw/rtl/weighted_centroid_peak_merge.sv */
// Top level of the weighted-centroid peak merge block.
//
//   Port group   Dir   Handshake          Carries
//   req_bus      in    valid / ready      entry_time, entry_count, is_last
//   rsp_bus      out   valid / ready      mean_time, total_count, sum_overflow, final_result
//   csr_*        in    csr_we             resolution (csr_wdata)
//
// An entry that produces no result passes through the capture, multiply and update states.
// A closing entry then adds the divider load, the bit-serial division that forms one
// quotient bit per cycle and the result load; a flush adds its own flush state before
// these; an entry that closes a cluster and ends the stream yields both results.
// Reset is synchronous and active high; no clearing pass is needed.
// A result waits in the output register while the next entry is taken; the block
// stalls only when a new result is ready and the previous one has not transferred.
module weighted_centroid_peak_merge #(
   parameter int TIME_BITS  = wcpm_pkg::TIME_BITS_DEF,
   parameter int COUNT_BITS = wcpm_pkg::COUNT_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [TIME_BITS-1:0] csr_wdata,
   wcpm_req_if.sink             req_bus,
   wcpm_rsp_if.source           rsp_bus
);

   wcpm_pkg::cmd_type  cmd;
   wcpm_pkg::stat_type stat;

   // Sequencer.
   wcpm_ctrl #(
      .TIME_BITS (TIME_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Accumulators, divider and result register.
   wcpm_dp #(
      .TIME_BITS  (TIME_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_time  (req_bus.entry_time),
      .req_count (req_bus.entry_count),
      .req_last  (req_bus.is_last),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .rsp_mean  (rsp_bus.mean_time),
      .rsp_total (rsp_bus.total_count),
      .rsp_ovf   (rsp_bus.sum_overflow),
      .rsp_final (rsp_bus.final_result)
   );

endmodule
